@@ rtl/core/tcpck_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpck_pkg
// Types and constants shared by the TCP/IPv4 checksum recompute block.
// ----------------------------------------------------------------------------
package tcpck_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned HDR_W    = 6;

    localparam logic [BYTE_W-1:0] PROTO_TCP       = 8'd6;
    localparam logic [WORD_W-1:0] OFF_IHL         = 16'd0;
    localparam logic [WORD_W-1:0] OFF_TOT_HI      = 16'd2;
    localparam logic [WORD_W-1:0] OFF_TOT_LO      = 16'd3;
    localparam logic [WORD_W-1:0] OFF_ADDR_FIRST  = 16'd12;
    localparam logic [WORD_W-1:0] OFF_ADDR_LAST   = 16'd19;
    localparam logic [WORD_W-1:0] REL_CKSUM_HI    = 16'd16;
    localparam logic [WORD_W-1:0] REL_CKSUM_LO    = 16'd17;
    localparam logic [WORD_W-1:0] OFF_SAT         = 16'hffff;
    localparam logic [HDR_W-1:0]  MIN_HDR_BYTES   = 6'd20;

    typedef struct packed {
        logic [BYTE_W-1:0] packet_byte;
        logic              last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_W-1:0] tcp_checksum;
        logic [WORD_W-1:0] total_length;
        logic              length_error;
    } t_out_beat;

    // end-of-packet snapshot handed to the finalizer
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [WORD_W-1:0] pad_word;
        logic [WORD_W-1:0] tcp_len;
        logic [WORD_W-1:0] total_length;
        logic              length_error;
    } t_fin;

endpackage

@@ rtl/core/tcp_ipv4_checksum_recompute.sv @@
// ----------------------------------------------------------------------------
// tcp_ipv4_checksum_recompute
// Streams an IPv4/TCP packet a byte per beat and returns its TCP checksum.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  input    in   i_valid / o_ready   i_data  (packet_byte, last_byte)
//  result   out  o_valid / i_ready   o_data  (tcp_checksum, total_length,
//                                             length_error)
//
//  One byte accepted per cycle; the running sum is updated in the cycle the
//  byte is taken. A last byte is snapshotted when it is accepted, and the
//  fold/invert result enters the output register once that is empty or read.
//  Synchronous active-low reset clears all packet state and valids.
//  A stalled result holds the snapshot stage; input stalls only while the
//  snapshot and output registers are both full and the result is not taken.
// ----------------------------------------------------------------------------
module tcp_ipv4_checksum_recompute (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tcpck_pkg::t_in_beat  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tcpck_pkg::t_out_beat o_data
);
    import tcpck_pkg::*;

    logic [WORD_W-1:0] r_byte_offset, n_byte_offset;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [HDR_W-1:0]  r_hdr, n_hdr;
    logic [WORD_W-1:0] r_tot, n_tot;
    logic [BYTE_W-1:0] r_pend, n_pend;

    logic              r_fin_v;
    t_fin              r_fin, n_fin;
    logic              r_out_v;
    t_out_beat         r_out;
    t_out_beat         w_result;

    logic              w_in_acc;
    logic              w_fin_move;
    logic [BYTE_W-1:0] w_b;
    logic [WORD_W-1:0] w_hdr16;
    logic [WORD_W-1:0] w_rel;
    logic [BYTE_W-1:0] w_v;
    logic              w_in_tcp;
    logic [SUM_W-1:0]  w_addr_term;
    logic [SUM_W-1:0]  w_word_term;
    logic [WORD_W:0]   w_received;
    logic [WORD_W:0]   w_end;
    logic [WORD_W:0]   w_span;

    assign w_fin_move = !r_out_v || i_ready;
    assign o_ready    = !r_fin_v || w_fin_move;
    assign w_in_acc   = i_valid && o_ready;
    assign w_b        = i_data.packet_byte;

    always_comb begin
        n_hdr = r_hdr;
        n_tot = r_tot;
        if (r_byte_offset == OFF_IHL) begin
            n_hdr = {w_b[3:0], 2'b00};
        end else if (r_byte_offset == OFF_TOT_HI) begin
            n_tot = {w_b, 8'h00};
        end else if (r_byte_offset == OFF_TOT_LO) begin
            n_tot = {r_tot[WORD_W-1:BYTE_W], w_b};
        end

        w_addr_term = '0;
        if (r_byte_offset >= OFF_ADDR_FIRST && r_byte_offset <= OFF_ADDR_LAST) begin
            if (r_byte_offset[0]) begin
                w_addr_term = {{(SUM_W-BYTE_W){1'b0}}, w_b};
            end else begin
                w_addr_term = {{(SUM_W-WORD_W){1'b0}}, w_b, 8'h00};
            end
        end

        w_hdr16  = {{(WORD_W-HDR_W){1'b0}}, n_hdr};
        w_rel    = r_byte_offset - w_hdr16;
        w_in_tcp = (r_byte_offset >= w_hdr16) && (r_byte_offset < n_tot);
        w_v      = (w_rel == REL_CKSUM_HI || w_rel == REL_CKSUM_LO) ? '0 : w_b;

        n_pend      = r_pend;
        w_word_term = '0;
        if (w_in_tcp) begin
            if (w_rel[0]) begin
                w_word_term = {{(SUM_W-WORD_W){1'b0}}, r_pend, w_v};
            end else begin
                n_pend = w_v;
            end
        end

        n_sum         = r_sum + w_addr_term + w_word_term;
        n_byte_offset = (r_byte_offset == OFF_SAT) ? r_byte_offset
                                                   : r_byte_offset + 16'd1;

        w_received = {1'b0, r_byte_offset} + 17'd1;
        w_end      = (w_received < {1'b0, n_tot}) ? w_received : {1'b0, n_tot};
        w_span     = w_end - {1'b0, w_hdr16};

        n_fin.sum          = n_sum;
        n_fin.pad_word     = ((w_end > {1'b0, w_hdr16}) && w_span[0]) ? {n_pend, 8'h00}
                                                                       : '0;
        n_fin.tcp_len      = n_tot - w_hdr16;
        n_fin.total_length = n_tot;
        n_fin.length_error = (n_hdr < MIN_HDR_BYTES) || (w_received < {1'b0, n_tot})
                           || (n_tot < w_hdr16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset <= '0;
            r_sum         <= '0;
            r_hdr         <= '0;
            r_tot         <= '0;
            r_pend        <= '0;
        end else if (w_in_acc) begin
            if (i_data.last_byte) begin
                r_byte_offset <= '0;
                r_sum         <= '0;
                r_hdr         <= '0;
                r_tot         <= '0;
                r_pend        <= '0;
            end else begin
                r_byte_offset <= n_byte_offset;
                r_sum         <= n_sum;
                r_hdr         <= n_hdr;
                r_tot         <= n_tot;
                r_pend        <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (w_in_acc && i_data.last_byte) begin
            r_fin_v <= 1'b1;
        end else if (w_fin_move) begin
            r_fin_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_data.last_byte) begin
            r_fin <= n_fin;
        end
    end

    tcpck_finalize u_finalize (
        .i_fin    (r_fin),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_fin_move) begin
            r_out_v <= r_fin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_move && r_fin_v) begin
            r_out <= w_result;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_data.last_byte) |=> (r_byte_offset == '0 && r_sum == '0))
        else $error("packet state not cleared after last beat");

    a_last_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_data.last_byte) |=> r_fin_v)
        else $error("last beat did not load snapshot");

    a_snap_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_v && w_fin_move) |=> o_valid)
        else $error("snapshot moved without output valid");

    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_v && !w_fin_move) |=> (r_fin_v && $stable(r_fin)))
        else $error("stalled snapshot changed");

endmodule

@@ rtl/core/tcpck_finalize.sv @@
// ----------------------------------------------------------------------------
// tcpck_finalize
// Adds pad, protocol and TCP length to the packet sum, folds and inverts.
// ----------------------------------------------------------------------------
module tcpck_finalize (
    input  tcpck_pkg::t_fin      i_fin,
    output tcpck_pkg::t_out_beat o_result
);
    import tcpck_pkg::*;

    logic [SUM_W-1:0]  w_total;
    logic [WORD_W:0]   w_fold1;
    logic [WORD_W:0]   w_fold2;

    always_comb begin
        w_total = i_fin.sum + {{(SUM_W-WORD_W){1'b0}}, i_fin.pad_word}
                + {{(SUM_W-BYTE_W){1'b0}}, PROTO_TCP}
                + {{(SUM_W-WORD_W){1'b0}}, i_fin.tcp_len};
        w_fold1 = {1'b0, w_total[SUM_W-1:WORD_W]} + {1'b0, w_total[WORD_W-1:0]};
        w_fold2 = w_fold1 + {{WORD_W{1'b0}}, w_fold1[WORD_W]};
        o_result.tcp_checksum = ~w_fold2[WORD_W-1:0];
        o_result.total_length = i_fin.total_length;
        o_result.length_error = i_fin.length_error;
    end

endmodule
